@@ rtl/core/mbe_pkg.sv @@
// Package for the escape-time block: fixed-point widths, cutoff reset value,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package mbe_pkg;

   // Fixed-point format of c and z
   localparam int FRAC_BITS = 28;
   localparam int C_W       = 32;
   // z stays below 16 in magnitude while it is still iterated
   localparam int Z_W       = FRAC_BITS + 5;
   localparam int P_W       = 2 * Z_W;
   localparam int S_W       = P_W + 1;
   localparam int CNT_W     = 16;

   // Escape radius squared (4.0) with 2*FRAC_BITS fraction bits
   localparam logic [S_W-1:0] RADIUS_SQ = S_W'(1) << (2 * FRAC_BITS + 2);

   localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic start;     // load c, clear z, count to one
      logic mul;       // capture the three products
      logic step;      // write z = z^2 + c, count up
      logic load_out;  // copy count into the result register
   } cmd_type;

   typedef struct packed {
      logic go_on;     // below cutoff and still inside the radius
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/mandelbrot_escape_time.sv @@
// Top level of the escape-time block: joins controller and datapath.
// Depends on mbe_pkg, mbe_ctrl and mbe_dp.
//
// Usage: present a point c (req_c_real, req_c_imag, signed, 28 fraction bits)
// with req_valid; a transaction completes at a clock edge where req_valid is
// high and req_stall is low. One result transaction per point carries
// rsp_iteration_count on rsp_valid; the receiver holds it off with rsp_stall.
// Each iteration is an ST_MUL state, which captures zr^2, zi^2 and zr*zi from
// three 33x33 multipliers, then an ST_UPD state, which tests the radius and
// adds c. The multiply/update loop runs until the count reaches the cutoff
// (default 100) or z leaves the radius; the block takes no new point while
// one is still in progress.
// The next point is accepted as soon as the result sits in the output
// register, even while the receiver stalls it; if the previous result is
// still not taken when a new one is done, the block waits with req_stall high.
// Reset (synchronous, active high) drops rsp_valid, returns to idle and sets
// the cutoff to 100. Write csr_wr_data with csr_wr_en only while idle.
`default_nettype none

module mandelbrot_escape_time (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire signed [31:0] req_c_real,
   input  wire signed [31:0] req_c_imag,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic       [15:0] rsp_iteration_count,
   input  wire               csr_wr_en,
   input  wire        [15:0] csr_wr_data
);
   import mbe_pkg::*;

   cmd_type    cmd;
   status_type status;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_c_real          (req_c_real),
      .req_c_imag          (req_c_imag),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

`default_nettype wire

@@ rtl/core/mbe_dp.sv @@
// Datapath of the escape-time block: z registers, three multipliers,
// radius test, update adders, iteration counter, cutoff and result registers.
// Depends on mbe_pkg.
`default_nettype none

module mbe_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire mbe_pkg::cmd_type        cmd,
   output mbe_pkg::status_type          status,
   input  wire  signed [31:0]           req_c_real,
   input  wire  signed [31:0]           req_c_imag,
   input  wire                          csr_wr_en,
   input  wire         [15:0]           csr_wr_data,
   output logic        [15:0]           rsp_iteration_count
);
   import mbe_pkg::*;

   logic signed [Z_W-1:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [Z_W-1:0] zr_in, zi_in;
   logic signed [P_W-1:0] sqr_ff, sqi_ff, crs_ff;
   logic signed [P_W-1:0] sqr_in, sqi_in, crs_in;
   logic        [S_W-1:0] sum_sq;
   logic signed [S_W-1:0] diff;
   logic signed [S_W-1:0] re_sh;
   logic signed [P_W-1:0] im_sh;
   logic        [CNT_W-1:0] count_ff, max_ff, out_ff;
   logic                  in_radius;

   // Hold the iteration cutoff
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // Form the three products of z
   always_comb begin
      sqr_in = zr_ff * zr_ff;
      sqi_in = zi_ff * zi_ff;
      crs_in = zr_ff * zi_ff;
   end

   // Test the radius and build the next z; floor comes from the arithmetic shift
   always_comb begin
      sum_sq    = {1'b0, sqr_ff} + {1'b0, sqi_ff};
      in_radius = (sum_sq <= RADIUS_SQ);
      diff      = S_W'(sqr_ff) - S_W'(sqi_ff);
      re_sh     = diff >>> FRAC_BITS;
      im_sh     = crs_ff >>> (FRAC_BITS - 1);
      zr_in     = Z_W'(re_sh) + cr_ff;
      zi_in     = Z_W'(im_sh) + ci_ff;
   end

   assign status.go_on = (count_ff < max_ff) && in_radius;

   // Advance the point state
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cr_ff    <= Z_W'(req_c_real);
         ci_ff    <= Z_W'(req_c_imag);
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= CNT_W'(1);
      end else if (cmd.step) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_ff + CNT_W'(1);
      end
      if (cmd.mul) begin
         sqr_ff <= sqr_in;
         sqi_ff <= sqi_in;
         crs_ff <= crs_in;
      end
      if (cmd.load_out) begin
         out_ff <= count_ff;
      end
   end

   assign rsp_iteration_count = out_ff;

endmodule

`default_nettype wire

@@ rtl/core/mbe_ctrl.sv @@
// Controller of the escape-time block: sequences multiply and update cycles,
// owns the input stall and the result valid. Depends on mbe_pkg.
`default_nettype none

module mbe_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   input  wire mbe_pkg::status_type status,
   output mbe_pkg::cmd_type         cmd
);
   import mbe_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (status.go_on) begin
               cmd.step = 1'b1;
               state_in = ST_MUL;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Set valid on a new result, drop it once taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
